// File: src/segx_pkg.sv
// ----------------------------------------------------------------------------
// segx_pkg
// widths, types and helpers shared by the segment intersection pipeline
// ----------------------------------------------------------------------------
package segx_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int FRAC_BITS   = 4;
    localparam int GATE_WIDTH  = 2 * COORD_WIDTH + 3;
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int DET_WIDTH   = 2 * DIFF_WIDTH + 1;
    localparam int NUM_WIDTH   = DET_WIDTH + DIFF_WIDTH + 2;
    localparam int DIV_WIDTH   = NUM_WIDTH;
    localparam int TDATA_IN_WIDTH  = 8 * COORD_WIDTH;
    localparam int TDATA_OUT_WIDTH = 40;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic [DIV_WIDTH-1:0]          mag_t;

    // one divider stage: partial remainder, remaining dividend bits, quotient
    typedef struct packed {
        logic             valid;
        mag_t             rem;
        mag_t             dvd;
        mag_t             quo;
        mag_t             dvs;
        logic             neg;
    } div_lane_t;

    // side information carried alongside the division lanes
    typedef struct packed {
        logic found;
        logic on_first;
        logic on_second;
    } seg_flags_t;

    function automatic coord_t sat_coord(input logic neg, input mag_t q);
        logic [DIV_WIDTH:0] lim;
        begin
            lim = neg ? ({{(DIV_WIDTH+1-COORD_WIDTH){1'b0}}, 1'b1, {(COORD_WIDTH-1){1'b0}}})
                      : ({{(DIV_WIDTH+2-COORD_WIDTH){1'b0}}, {(COORD_WIDTH-1){1'b1}}});
            if ({1'b0, q} > lim)
                sat_coord = neg ? coord_t'({1'b1, {(COORD_WIDTH-1){1'b0}}})
                                : coord_t'({1'b0, {(COORD_WIDTH-1){1'b1}}});
            else
                sat_coord = neg ? coord_t'(-q[COORD_WIDTH-1:0]) : coord_t'(q[COORD_WIDTH-1:0]);
        end
    endfunction

endpackage

// File: src/segx_div_cell.sv
// ----------------------------------------------------------------------------
// segx_div_cell
// one restoring division step for the x and y lanes, registered
// ----------------------------------------------------------------------------
module segx_div_cell (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  segx_pkg::div_lane_t    x_in,
    input  segx_pkg::div_lane_t    y_in,
    input  segx_pkg::seg_flags_t   flags_in,
    output segx_pkg::div_lane_t    x_out,
    output segx_pkg::div_lane_t    y_out,
    output segx_pkg::seg_flags_t   flags_out
);
    import segx_pkg::*;

    div_lane_t  x_reg, x_next, y_reg, y_next;
    seg_flags_t flags_reg;

    function automatic div_lane_t step(input div_lane_t a);
        div_lane_t r;
        mag_t      t;
        begin
            r   = a;
            t   = {a.rem[DIV_WIDTH-2:0], a.dvd[DIV_WIDTH-1]};
            r.dvd = {a.dvd[DIV_WIDTH-2:0], 1'b0};
            if (t >= a.dvs) begin
                r.rem = t - a.dvs;
                r.quo = {a.quo[DIV_WIDTH-2:0], 1'b1};
            end else begin
                r.rem = t;
                r.quo = {a.quo[DIV_WIDTH-2:0], 1'b0};
            end
            step = r;
        end
    endfunction

    always_comb begin
        x_next = step(x_in);
        y_next = step(y_in);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg.valid <= 1'b0;
            y_reg.valid <= 1'b0;
        end else if (en) begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            flags_reg <= flags_in;
        end
    end

    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign flags_out = flags_reg;

endmodule

// File: src/segment_intersection.sv
// ----------------------------------------------------------------------------
// segment_intersection
// 2d segment intersection: determinant gate, crossing point, on-segment flags
// ----------------------------------------------------------------------------
// a request passes stage registers 1 to 4, the divider cells and the output register
// throughput: one request per cycle; the whole pipe advances when the output
//   register is empty or being taken, so a stalled result holds everything
// the divider is a chain of DIV_WIDTH identical cells, one quotient bit each
// reset clears all valid bits and sets det_gate to 1
module segment_intersection (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // det_gate register
    input  logic                                 cfg_wr_en,
    input  logic [segx_pkg::GATE_WIDTH-1:0]      cfg_wr_data,
    // request: s1x, s1y, e1x, e1y, s2x, s2y, e2x, e2y (16 bits each, low first)
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [segx_pkg::TDATA_IN_WIDTH-1:0]  s_tdata,
    // result: found, intersect_x, intersect_y, on_first, on_second, zero pad
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [segx_pkg::TDATA_OUT_WIDTH-1:0] m_tdata
);
    import segx_pkg::*;

    localparam int NCELL = DIV_WIDTH;

    logic adv;
    logic [GATE_WIDTH-1:0] gate_reg;

    // global advance: output empty or drained
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            gate_reg <= GATE_WIDTH'(1);
        else if (cfg_wr_en)
            gate_reg <= cfg_wr_data;
    end

    // stage 1: unpack and take the differences
    logic v1_reg;
    logic signed [DIFF_WIDTH-1:0] d1x_reg, d1y_reg, d2x_reg, d2y_reg, ox_reg, oy_reg;
    coord_t s1x_reg, s1y_reg;
    coord_t i_s1x, i_s1y, i_e1x, i_e1y, i_s2x, i_s2y, i_e2x, i_e2y;

    assign i_s1x = s_tdata[0*COORD_WIDTH +: COORD_WIDTH];
    assign i_s1y = s_tdata[1*COORD_WIDTH +: COORD_WIDTH];
    assign i_e1x = s_tdata[2*COORD_WIDTH +: COORD_WIDTH];
    assign i_e1y = s_tdata[3*COORD_WIDTH +: COORD_WIDTH];
    assign i_s2x = s_tdata[4*COORD_WIDTH +: COORD_WIDTH];
    assign i_s2y = s_tdata[5*COORD_WIDTH +: COORD_WIDTH];
    assign i_e2x = s_tdata[6*COORD_WIDTH +: COORD_WIDTH];
    assign i_e2y = s_tdata[7*COORD_WIDTH +: COORD_WIDTH];

    always_ff @(posedge aclk) begin
        if (!aresetn)
            v1_reg <= 1'b0;
        else if (adv)
            v1_reg <= s_tvalid;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            d1x_reg <= DIFF_WIDTH'(i_e1x) - DIFF_WIDTH'(i_s1x);
            d1y_reg <= DIFF_WIDTH'(i_e1y) - DIFF_WIDTH'(i_s1y);
            d2x_reg <= DIFF_WIDTH'(i_e2x) - DIFF_WIDTH'(i_s2x);
            d2y_reg <= DIFF_WIDTH'(i_e2y) - DIFF_WIDTH'(i_s2y);
            ox_reg  <= DIFF_WIDTH'(i_s1x) - DIFF_WIDTH'(i_s2x);
            oy_reg  <= DIFF_WIDTH'(i_s1y) - DIFF_WIDTH'(i_s2y);
            s1x_reg <= i_s1x;
            s1y_reg <= i_s1y;
        end
    end

    // stage 2: the six 17x17 products
    logic v2_reg;
    logic signed [2*DIFF_WIDTH-1:0] p_a_reg, p_b_reg, p_c_reg, p_d_reg, p_e_reg, p_f_reg;
    logic signed [DIFF_WIDTH-1:0]   d1x2_reg, d1y2_reg;
    coord_t s1x2_reg, s1y2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            v2_reg <= 1'b0;
        else if (adv)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p_a_reg  <= d1y_reg * d2x_reg;
            p_b_reg  <= d1x_reg * d2y_reg;
            p_c_reg  <= ox_reg * d2y_reg;
            p_d_reg  <= oy_reg * d2x_reg;
            p_e_reg  <= ox_reg * d1y_reg;
            p_f_reg  <= oy_reg * d1x_reg;
            d1x2_reg <= d1x_reg;
            d1y2_reg <= d1y_reg;
            s1x2_reg <= s1x_reg;
            s1y2_reg <= s1y_reg;
        end
    end

    // stage 3: determinant, numerators, gate and flags
    logic v3_reg;
    logic signed [DET_WIDTH-1:0] det_reg, n1_reg;
    logic signed [DET_WIDTH-1:0] det_c, n1_c, n2_c;
    logic [DET_WIDTH-1:0] adet_c, an1_c, an2_c;
    logic ok_c, f1_c, f2_c, ok_reg, f1_reg, f2_reg;
    logic signed [DIFF_WIDTH-1:0] d1x3_reg, d1y3_reg;
    coord_t s1x3_reg, s1y3_reg;

    always_comb begin
        det_c  = DET_WIDTH'(p_a_reg) - DET_WIDTH'(p_b_reg);
        n1_c   = DET_WIDTH'(p_c_reg) - DET_WIDTH'(p_d_reg);
        n2_c   = DET_WIDTH'(p_e_reg) - DET_WIDTH'(p_f_reg);
        adet_c = det_c[DET_WIDTH-1] ? DET_WIDTH'(-det_c) : DET_WIDTH'(det_c);
        an1_c  = n1_c[DET_WIDTH-1] ? DET_WIDTH'(-n1_c) : DET_WIDTH'(n1_c);
        an2_c  = n2_c[DET_WIDTH-1] ? DET_WIDTH'(-n2_c) : DET_WIDTH'(n2_c);
        ok_c   = (det_c != '0) && ({1'b0, adet_c} >= (DET_WIDTH+1)'(gate_reg));
        f1_c   = (n1_c == '0) ||
                 ((n1_c[DET_WIDTH-1] == det_c[DET_WIDTH-1]) && (adet_c >= an1_c));
        f2_c   = (n2_c == '0) ||
                 ((n2_c[DET_WIDTH-1] == det_c[DET_WIDTH-1]) && (adet_c >= an2_c));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            v3_reg <= 1'b0;
        else if (adv)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            det_reg  <= det_c;
            n1_reg   <= n1_c;
            ok_reg   <= ok_c;
            f1_reg   <= ok_c && f1_c;
            f2_reg   <= ok_c && f2_c;
            d1x3_reg <= d1x2_reg;
            d1y3_reg <= d1y2_reg;
            s1x3_reg <= s1x2_reg;
            s1y3_reg <= s1y2_reg;
        end
    end

    // stage 4: dividend products s*det and d*n1
    logic v4_reg;
    logic signed [DET_WIDTH+COORD_WIDTH-1:0] q_sx_reg, q_sy_reg;
    logic signed [DET_WIDTH+DIFF_WIDTH-1:0]  q_dx_reg, q_dy_reg;
    logic signed [DET_WIDTH-1:0] det4_reg;
    seg_flags_t fl4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            v4_reg <= 1'b0;
        else if (adv)
            v4_reg <= v3_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            q_sx_reg <= s1x3_reg * det_reg;
            q_sy_reg <= s1y3_reg * det_reg;
            q_dx_reg <= d1x3_reg * n1_reg;
            q_dy_reg <= d1y3_reg * n1_reg;
            det4_reg <= det_reg;
            fl4_reg  <= '{found: ok_reg, on_first: f1_reg, on_second: f2_reg};
        end
    end

    // stage 5 (combinational into the chain): signs and magnitudes
    logic signed [NUM_WIDTH-1:0] numx_c, numy_c;
    mag_t adiv_c;
    div_lane_t lane_x0, lane_y0;

    always_comb begin
        numx_c = NUM_WIDTH'(q_sx_reg) + NUM_WIDTH'(q_dx_reg);
        numy_c = NUM_WIDTH'(q_sy_reg) + NUM_WIDTH'(q_dy_reg);
        adiv_c = det4_reg[DET_WIDTH-1] ? mag_t'(-NUM_WIDTH'(det4_reg))
                                       : mag_t'(NUM_WIDTH'(det4_reg));
        lane_x0.valid = v4_reg;
        lane_x0.rem   = '0;
        lane_x0.quo   = '0;
        lane_x0.dvs   = fl4_reg.found ? adiv_c : mag_t'(1);
        lane_x0.dvd   = !fl4_reg.found ? '0 :
                        numx_c[NUM_WIDTH-1] ? mag_t'(-numx_c) : mag_t'(numx_c);
        lane_x0.neg   = numx_c[NUM_WIDTH-1] ^ det4_reg[DET_WIDTH-1];
        lane_y0       = lane_x0;
        lane_y0.dvd   = !fl4_reg.found ? '0 :
                        numy_c[NUM_WIDTH-1] ? mag_t'(-numy_c) : mag_t'(numy_c);
        lane_y0.neg   = numy_c[NUM_WIDTH-1] ^ det4_reg[DET_WIDTH-1];
    end

    // divider chain: one quotient bit per cell
    div_lane_t  cx [NCELL+1];
    div_lane_t  cy [NCELL+1];
    seg_flags_t cf [NCELL+1];

    assign cx[0] = lane_x0;
    assign cy[0] = lane_y0;
    assign cf[0] = fl4_reg;

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        segx_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (adv),
            .x_in      (cx[g]),
            .y_in      (cy[g]),
            .flags_in  (cf[g]),
            .x_out     (cx[g+1]),
            .y_out     (cy[g+1]),
            .flags_out (cf[g+1])
        );
    end

    // output register: saturate and pack
    logic      out_v_reg;
    logic [TDATA_OUT_WIDTH-1:0] out_d_reg;
    coord_t    ox_c, oy_c;

    assign ox_c = sat_coord(cx[NCELL].neg, cx[NCELL].quo);
    assign oy_c = sat_coord(cy[NCELL].neg, cy[NCELL].quo);

    always_ff @(posedge aclk) begin
        if (!aresetn)
            out_v_reg <= 1'b0;
        else if (adv)
            out_v_reg <= cx[NCELL].valid;
    end

    always_ff @(posedge aclk) begin
        if (adv)
            out_d_reg <= {{(TDATA_OUT_WIDTH-3-2*COORD_WIDTH){1'b0}},
                          cf[NCELL].on_second, cf[NCELL].on_first,
                          cf[NCELL].found ? oy_c : coord_t'(0),
                          cf[NCELL].found ? ox_c : coord_t'(0),
                          cf[NCELL].found};
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_d_reg;

endmodule

// File: tb/segment_intersection_tb.sv
// ----------------------------------------------------------------------------
// segment_intersection_tb
// self-checking bench for the segment intersection pipeline: directed corner
// pairs, then random pairs under several det_gate settings and idle patterns,
// every result checked field by field against an in-bench exact predictor
// ----------------------------------------------------------------------------
module segment_intersection_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import segx_pkg::*;

    // one request: both segments, start then end
    typedef struct {
        coord_t s1x, s1y, e1x, e1y, s2x, s2y, e2x, e2y;
    } seg_pair_t;

    // one result as it leaves the block
    typedef struct {
        logic   found;
        coord_t ix;
        coord_t iy;
        logic   on_first;
        logic   on_second;
    } crossing_t;

    // keeps the expected crossings in request order and compares results
    class crossing_scoreboard;
        crossing_t    expected_q[$];
        longint       gate;
        int unsigned  mismatches;
        int unsigned  checked;
        int unsigned  found_count;

        function new();
            gate = 1;
        endfunction

        function coord_t clamp(longint v);
            if (v > 32767) return coord_t'(16'sh7fff);
            if (v < -32768) return coord_t'(16'sh8000);
            return coord_t'(v);
        endfunction

        function logic unit_span(longint n, longint d);
            if (n == 0) return 1'b1;
            if ((n < 0) != (d < 0)) return 1'b0;
            return ((d < 0 ? -d : d) >= (n < 0 ? -n : n));
        endfunction

        // exact integer crossing of the two lines
        function void note_request(seg_pair_t p);
            longint s1x, s1y, d1x, d1y, d2x, d2y, ox, oy, det, n1, n2;
            crossing_t c;
            s1x = p.s1x;
            s1y = p.s1y;
            d1x = longint'(p.e1x) - p.s1x;
            d1y = longint'(p.e1y) - p.s1y;
            d2x = longint'(p.e2x) - p.s2x;
            d2y = longint'(p.e2y) - p.s2y;
            det = d1y * d2x - d1x * d2y;
            c = '{1'b0, '0, '0, 1'b0, 1'b0};
            if (det != 0 && (det < 0 ? -det : det) >= gate) begin
                ox = s1x - p.s2x;
                oy = s1y - p.s2y;
                n1 = ox * d2y - oy * d2x;
                n2 = ox * d1y - oy * d1x;
                c.found     = 1'b1;
                c.ix        = clamp((s1x * det + d1x * n1) / det);
                c.iy        = clamp((s1y * det + d1y * n1) / det);
                c.on_first  = unit_span(n1, det);
                c.on_second = unit_span(n2, det);
            end
            expected_q.push_back(c);
        endfunction

        function void check_result(crossing_t a);
            crossing_t e;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: found=%0b x=%0d y=%0d",
                             a.found, a.ix, a.iy);
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (e.found) found_count++;
            if (a.found !== e.found || a.ix !== e.ix || a.iy !== e.iy ||
                a.on_first !== e.on_first || a.on_second !== e.on_second) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: exp f=%0b x=%0d y=%0d o1=%0b o2=%0b, ",
                              "got f=%0b x=%0d y=%0d o1=%0b o2=%0b"},
                             e.found, e.ix, e.iy, e.on_first, e.on_second,
                             a.found, a.ix, a.iy, a.on_first, a.on_second);
            end
        endfunction
    endclass

    logic                       aclk;
    logic                       aresetn;
    logic                       cfg_wr_en;
    logic [GATE_WIDTH-1:0]      cfg_wr_data;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [TDATA_IN_WIDTH-1:0]  s_tdata;   // s1x, s1y, e1x, e1y, s2x, s2y, e2x, e2y
    logic                       m_tvalid;
    logic                       m_tready;
    logic [TDATA_OUT_WIDTH-1:0] m_tdata;   // found, intersect_x, intersect_y, on_first, on_second

    crossing_scoreboard sb;
    seg_pair_t          sent_q[$];     // requests on the bus, awaiting accept
    int unsigned        send_idle_pct;
    int unsigned        recv_stall_pct;

    segment_intersection i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // receiver back-pressure, redrawn every cycle
    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // accepted requests feed the predictor, accepted results are checked
    always @(posedge aclk) begin
        crossing_t r;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_request(sent_q.pop_front());
            if (m_tvalid && m_tready) begin
                r.found     = m_tdata[0];
                r.ix        = m_tdata[16:1];
                r.iy        = m_tdata[32:17];
                r.on_first  = m_tdata[33];
                r.on_second = m_tdata[34];
                sb.check_result(r);
            end
        end
    end

    // present one request, with a random idle gap first
    task automatic send_pair(seg_pair_t p);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {p.e2y, p.e2x, p.s2y, p.s2x, p.e1y, p.e1x, p.s1y, p.s1x};
        sent_q.push_back(p);
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0 || sent_q.size() != 0)
            @(posedge aclk);
        // gate writes only once the pipe is empty
        repeat (70) @(posedge aclk);
    endtask

    task automatic write_gate(logic [GATE_WIDTH-1:0] g);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= g;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.gate = longint'(g);
    endtask

    function automatic seg_pair_t make_pair(coord_t a, coord_t b, coord_t c, coord_t d,
                                            coord_t e, coord_t f, coord_t g, coord_t h);
        seg_pair_t p;
        p = '{a, b, c, d, e, f, g, h};
        return p;
    endfunction

    function automatic coord_t rnd_coord(int unsigned span);
        return coord_t'(int'($urandom_range(2 * span)) - int'(span));
    endfunction

    // random pair: small segments half the time, full range a quarter of the time,
    // some nearly parallel, some sharing an endpoint
    function automatic seg_pair_t random_pair();
        seg_pair_t p;
        int unsigned kind;
        kind = $urandom_range(99);
        p.s1x = rnd_coord(600); p.s1y = rnd_coord(600);
        p.e1x = rnd_coord(600); p.e1y = rnd_coord(600);
        p.s2x = rnd_coord(600); p.s2y = rnd_coord(600);
        p.e2x = rnd_coord(600); p.e2y = rnd_coord(600);
        if (kind < 25) begin
            p = '{coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom), coord_t'($urandom)};
        end else if (kind < 40) begin
            // second direction equals the first plus a tiny skew
            p.e2x = p.s2x + (p.e1x - p.s1x) + rnd_coord(2);
            p.e2y = p.s2y + (p.e1y - p.s1y) + rnd_coord(2);
        end else if (kind < 50) begin
            p.s2x = p.e1x;
            p.s2y = p.e1y;
        end
        return p;
    endfunction

    localparam coord_t CMAX = 16'sh7fff;
    localparam coord_t CMIN = 16'sh8000;

    initial begin
        logic [GATE_WIDTH-1:0] gates[5];
        seg_pair_t directed[$];
        sb             = new();
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // plain cross at the origin, endpoints touching (t exactly 1 and 0), lines crossing past the first end
        directed.push_back(make_pair(-16, 0, 16, 0, 0, -16, 0, 16));
        directed.push_back(make_pair(0, 0, 16, 16, 16, 16, 32, 0));
        directed.push_back(make_pair(0, 0, 16, 0, 32, -16, 32, 16));
        // parallel and collinear pairs: zero determinant
        directed.push_back(make_pair(0, 0, 16, 16, 0, 16, 16, 32));
        directed.push_back(make_pair(0, 0, 32, 0, 16, 0, 48, 0));
        // degenerate segments
        directed.push_back(make_pair(5, 5, 5, 5, 0, 0, 16, 16));
        directed.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
        // coordinate extremes and near-parallel pairs, some with a crossing point far off range so it saturates
        directed.push_back(make_pair(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN));
        directed.push_back(make_pair(CMAX, CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX));
        directed.push_back(make_pair(0, 0, 1, 0, CMIN, CMIN, CMAX, CMIN + 1));
        directed.push_back(make_pair(0, 0, 1, 1, 0, 1, 1, 3));
        directed.push_back(make_pair(0, 0, -1, -1, 0, -1, -1, -3));
        directed.push_back(make_pair(CMAX, 0, CMIN, 1, 0, CMAX, 1, CMIN));
        directed.push_back(make_pair(CMIN, CMAX, CMAX, CMIN, 0, 0, 1, 1));
        // smallest nonzero determinant
        directed.push_back(make_pair(0, 0, 1, 0, 0, 0, 0, 1));
        directed.push_back(make_pair(0, 0, 0, 1, 0, 0, 1, 0));
        foreach (directed[i]) send_pair(directed[i]);

        gates = '{35'd1, 35'd0, 35'h4_0000_0000, 35'd2000, 35'h7_ffff_ffff};
        for (int ph = 0; ph < 5; ph++) begin
            drain();
            write_gate(ph == 0 ? 35'd1 : gates[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            for (int n = 0; n < 207; n++) begin
                // hold off mid-phase until the pipe has emptied
                if (ph == 2 && n == 100) begin
                    s_tvalid <= 1'b0;
                    while (sb.expected_q.size() != 0 || sent_q.size() != 0)
                        @(posedge aclk);
                end
                send_pair(random_pair());
            end
        end

        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0 || sent_q.size() != 0)
            @(posedge aclk);
        repeat (80) @(posedge aclk);

        $display("checked %0d results, %0d with a crossing, across 5 gate settings",
                 sb.checked, sb.found_count);
        $display("idle patterns: none, sender gaps, receiver stalls, both; %0d mismatches",
                 sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
